@@ rtl/core/rprop_pkg.sv @@
package rprop_pkg;

  localparam int IDX_W       = 10;
  localparam int GRAD_W      = 32;
  localparam int STEP_W      = 24;
  localparam int CHANGE_W    = 25;
  localparam int INC_W       = 18;
  localparam int DEC_W       = 16;
  localparam int SIGN_W      = 2;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = STEP_W + INC_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [STEP_W-1:0] INIT_STEP      = 24'd6554;
  localparam logic [INC_W-1:0]  INC_RESET      = 18'd78643;
  localparam logic [DEC_W-1:0]  DEC_RESET      = 16'd32768;
  localparam logic [STEP_W-1:0] CEILING_RESET  = 24'd3276800;
  localparam logic [STEP_W-1:0] FLOOR_RESET    = 24'd0;

  // Stored sign codes.
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  // Update modes carried in tuser.
  localparam logic OP_PLAIN  = 1'b0;
  localparam logic OP_IRPROP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INCREASE = 2'd0,
    REG_DECREASE = 2'd1,
    REG_CEILING  = 2'd2,
    REG_FLOOR    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHANGE_W-1:0] change;
    logic [SIGN_W-1:0]   sign;
    logic [STEP_W-1:0]   step;
  } state_t;

  function automatic logic [CHANGE_W-1:0] sign_apply(input logic [SIGN_W-1:0] sgn,
                                                     input logic [STEP_W-1:0] step);
    logic [CHANGE_W-1:0] ext;
    ext = {1'b0, step};
    unique case (sgn)
      SIGN_POS: sign_apply = ext;
      SIGN_NEG: sign_apply = {CHANGE_W{1'b0}} - ext;
      default:  sign_apply = {CHANGE_W{1'b0}};
    endcase
  endfunction

endpackage

@@ rtl/core/rprop_weight_step_update.sv @@
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tdata: index, gradient, direction_wrong
//                                           tuser: opcode
// out_     master     out_tvalid/out_tready tdata: weight_change, step_size
// cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item is accepted per cycle unless out_ stalls or an index hazard holds; its result is
// registered in stage 1, stage 2 and the output register before it appears on out_. An item
// whose index matches one of the two items still ahead of the state write-back waits for it.
// After reset a clearing pass writes the initial state into every entry of the state
// memory; in_tready stays low meanwhile, while configuration writes are taken.
// A low out_tready while out_tvalid is high freezes the whole pipeline, including the state memory read.
module rprop_weight_step_update #(
  parameter int WEIGHT_COUNT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [9:0] weight_index, [41:10] gradient, [42] direction_wrong, rest zero
  input  logic [rprop_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] opcode
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [24:0] weight_change, [48:25] step_size, rest zero
  output logic [rprop_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rprop_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rprop_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rprop_pkg::*;

  localparam int AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WEIGHT_COUNT - 1);

  // Configuration registers.
  logic [INC_W-1:0]  inc_r;
  logic [DEC_W-1:0]  dec_r;
  logic [STEP_W-1:0] ceiling_r;
  logic [STEP_W-1:0] floor_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r     <= INC_RESET;
      dec_r     <= DEC_RESET;
      ceiling_r <= CEILING_RESET;
      floor_r   <= FLOOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INCREASE: inc_r     <= cfg_data[INC_W-1:0];
        REG_DECREASE: dec_r     <= cfg_data[DEC_W-1:0];
        REG_CEILING:  ceiling_r <= cfg_data[STEP_W-1:0];
        REG_FLOOR:    floor_r   <= cfg_data[STEP_W-1:0];
      endcase
    end
  end

  // Input unpacking.
  logic [IDX_W-1:0]    in_idx;
  logic [GRAD_W-1:0]   in_grad;
  logic                in_wrong;
  logic [IDX_W+AW-1:0] in_idx_ext;
  logic [AW-1:0]       in_addr;
  logic                in_range;

  assign in_idx     = in_tdata[IDX_W-1:0];
  assign in_grad    = in_tdata[IDX_W+GRAD_W-1:IDX_W];
  assign in_wrong   = in_tdata[IDX_W+GRAD_W];
  assign in_idx_ext = {{AW{1'b0}}, in_idx};
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_range   = (32'(in_idx) < 32'(WEIGHT_COUNT));

  // Pipeline control.
  logic out_valid_r;
  logic s1_valid_r;
  logic s2_valid_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic adv;
  logic hazard;
  logic clr_done_r;
  logic [AW-1:0] clr_cnt_r;
  logic s1_valid_nxt;

  assign adv    = !out_valid_r || out_tready;
  // The state memory is written as an item leaves the second stage, so a later item
  // on the same index must not read before that write has landed.
  assign hazard = (s1_valid_r && (s1_idx_r == in_idx)) ||
                  (s2_valid_r && (s2_idx_r == in_idx));
  assign in_tready    = adv && clr_done_r && !hazard;
  assign s1_valid_nxt = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == LAST_ADDR) begin
        clr_done_r <= 1'b1;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // State memory.
  state_t          mem [WEIGHT_COUNT];
  state_t          rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  state_t          mem_wdata;
  state_t          s2_state;
  logic [AW-1:0]   s2_addr;
  logic            s2_range_r;

  assign mem_we    = !clr_done_r || (adv && s2_valid_r && s2_range_r);
  assign mem_waddr = clr_done_r ? s2_addr : clr_cnt_r;
  assign mem_wdata = clr_done_r ? s2_state
                                : state_t'{change: '0, sign: SIGN_ZERO, step: INIT_STEP};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // Stage 1: sign compare, factor select and the step multiply.
  logic s1_range_r, s1_op_r, s1_wrong_r, s1_gneg_r, s1_gzero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r   <= in_idx;
      s1_range_r <= in_range;
      s1_op_r    <= in_tuser;
      s1_wrong_r <= in_wrong;
      s1_gneg_r  <= in_grad[GRAD_W-1];
      s1_gzero_r <= (in_grad == '0);
    end
  end

  logic              s1_ppos, s1_pneg;
  logic [SIGN_W-1:0] s1_sign;
  logic [INC_W-1:0]  s1_factor;
  logic [PROD_W-1:0] s1_prod;

  assign s1_ppos = !s1_gzero_r && (((rd_data_r.sign == SIGN_POS) && !s1_gneg_r) ||
                                   ((rd_data_r.sign == SIGN_NEG) && s1_gneg_r));
  assign s1_pneg = !s1_gzero_r && (((rd_data_r.sign == SIGN_POS) && s1_gneg_r) ||
                                   ((rd_data_r.sign == SIGN_NEG) && !s1_gneg_r));
  assign s1_sign   = s1_gzero_r ? SIGN_ZERO : (s1_gneg_r ? SIGN_NEG : SIGN_POS);
  // Only one of the two products is ever needed, so one multiplier serves both.
  assign s1_factor = s1_ppos ? inc_r : {{(INC_W-DEC_W){1'b0}}, dec_r};
  assign s1_prod   = rd_data_r.step * s1_factor;

  // Stage 2: truncate, clamp, select the change and the new state.
  logic                s2_op_r, s2_wrong_r, s2_ppos_r, s2_pneg_r;
  logic [SIGN_W-1:0]   s2_sign_r;
  logic [STEP_W-1:0]   s2_step_r;
  logic [CHANGE_W-1:0] s2_pchange_r;
  logic [PROD_W-1:0]   s2_prod_r;
  logic [IDX_W+AW-1:0] s2_idx_ext;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_idx_r     <= s1_idx_r;
      s2_range_r   <= s1_range_r;
      s2_op_r      <= s1_op_r;
      s2_wrong_r   <= s1_wrong_r;
      s2_ppos_r    <= s1_ppos;
      s2_pneg_r    <= s1_pneg;
      s2_sign_r    <= s1_sign;
      s2_step_r    <= rd_data_r.step;
      s2_pchange_r <= rd_data_r.change;
      s2_prod_r    <= s1_prod;
    end
  end

  assign s2_idx_ext = {{AW{1'b0}}, s2_idx_r};
  assign s2_addr    = s2_idx_ext[AW-1:0];

  logic [PROD_W-FRAC_W-1:0] s2_scaled;
  logic [STEP_W-1:0]        s2_grown, s2_shrunk, s2_floored;
  logic [STEP_W-1:0]        s2_new_step;
  logic [CHANGE_W-1:0]      s2_change;
  logic [SIGN_W-1:0]        s2_new_sign;

  assign s2_scaled  = s2_prod_r[PROD_W-1:FRAC_W];
  assign s2_grown   = (s2_scaled > {{(PROD_W-FRAC_W-STEP_W){1'b0}}, ceiling_r}) ?
                      ceiling_r : s2_scaled[STEP_W-1:0];
  // The shrink factor is below one, so the shrunk step always fits.
  assign s2_shrunk  = s2_prod_r[STEP_W+FRAC_W-1:FRAC_W];
  assign s2_floored = (s2_shrunk < floor_r) ? floor_r : s2_shrunk;

  always_comb begin
    s2_new_step = s2_step_r;
    s2_change   = '0;
    s2_new_sign = s2_sign_r;
    unique case (s2_op_r)
      OP_PLAIN: begin
        s2_change = sign_apply(s2_sign_r, s2_step_r);
        priority if (s2_ppos_r) begin
          s2_new_step = s2_grown;
        end else if (s2_pneg_r) begin
          s2_new_step = s2_shrunk;
        end else begin
          s2_new_step = s2_step_r;
        end
      end
      OP_IRPROP: begin
        priority if (s2_ppos_r) begin
          s2_new_step = s2_grown;
          s2_change   = sign_apply(s2_sign_r, s2_grown);
        end else if (s2_pneg_r) begin
          // On a sign flip the last change is backed out only if the error rose.
          s2_new_step = s2_floored;
          s2_change   = s2_wrong_r ? ({CHANGE_W{1'b0}} - s2_pchange_r) : '0;
          s2_new_sign = SIGN_ZERO;
        end else begin
          s2_change   = sign_apply(s2_sign_r, s2_step_r);
        end
      end
    endcase
  end

  assign s2_state = state_t'{change: s2_change, sign: s2_new_sign, step: s2_new_step};

  // Stage 3: output register.
  logic [CHANGE_W-1:0] out_change_r;
  logic [STEP_W-1:0]   out_step_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_change_r <= s2_range_r ? s2_change : '0;
      out_step_r   <= s2_range_r ? s2_new_step : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHANGE_W-STEP_W){1'b0}}, out_step_r, out_change_r};

endmodule
